// ----- rtl/core/psc_pkg.sv -----
// Shared types, sizes and the pattern table of the severity pattern scanner.
package psc_pkg;

	// Message and window sizes.
	localparam int SCAN_LIMIT    = 65536;
	localparam int CNT_W         = $clog2(SCAN_LIMIT + 1);
	localparam int PATTERN_TOTAL = 65;
	localparam int WINDOW_LEN    = 29;
	localparam int WIN_BITS      = 8 * WINDOW_LEN;
	localparam int CLASS_TOTAL   = 10;
	localparam int SEV_LEVELS    = 8;

	// Severity codes.
	localparam logic [2:0] LEVEL_NONE = 3'd0;
	localparam logic [2:0] LEVEL_INFO = 3'd1;

	// Category code for no category.
	localparam logic [3:0] CAT_NONE = 4'd0;

	typedef logic [7:0]               byte_t;
	typedef logic [2:0]               sev_t;
	typedef logic [3:0]               cat_t;
	typedef logic [WIN_BITS-1:0]      win_t;
	typedef logic [PATTERN_TOTAL-1:0] hits_t;

	// One pattern: text right aligned (last character in the low byte), zero padded.
	typedef struct packed {
		win_t txt;
		cat_t cls;
		sev_t sev;
	} pat_t;

	// Pattern table in priority order; the class numbers never decrease along the table.
	localparam pat_t PAT_ROM [PATTERN_TOTAL] = '{
		'{232'h616d7369696e69746661696c6564, 4'd1, 3'd5},
		'{232'h616d7369636f6e74657874, 4'd1, 3'd5},
		'{232'h616d73697574696c73, 4'd1, 3'd5},
		'{232'h616d73692e646c6c, 4'd1, 3'd4},
		'{"setvalue($null,$true)", 4'd1, 3'd5},
		'{232'h627970617373616d7369, 4'd1, 3'd5},
		'{"invoke-reflectivepeinjection", 4'd2, 3'd5},
		'{"invoke-shellcode", 4'd2, 3'd5},
		'{"[reflection.assembly]::load", 4'd2, 3'd4},
		'{"assembly::loadwithpartialname", 4'd2, 3'd4},
		'{"loadlibrarya", 4'd2, 3'd3},
		'{"iex(", 4'd3, 3'd4},
		'{"invoke-expression", 4'd3, 3'd4},
		'{"net.webclient", 4'd3, 3'd3},
		'{"downloadstring(", 4'd3, 3'd4},
		'{"downloadfile(", 4'd3, 3'd3},
		'{"bitstransfer", 4'd3, 3'd3},
		'{"wget ", 4'd3, 3'd2},
		'{"curl ", 4'd3, 3'd2},
		'{"start-bitstransfer", 4'd3, 3'd3},
		'{232'h6d696d696b61747a, 4'd4, 3'd5},
		'{"sekurlsa", 4'd4, 3'd5},
		'{"lsadump", 4'd4, 3'd5},
		'{"logonpasswords", 4'd4, 3'd5},
		'{"wce.exe", 4'd4, 3'd5},
		'{"procdump", 4'd4, 3'd4},
		'{"lsass", 4'd4, 3'd4},
		'{"[char]", 4'd5, 3'd3},
		'{"-join(", 4'd5, 3'd3},
		'{"replace(',','')", 4'd5, 3'd3},
		'{"env:comspec", 4'd5, 3'd3},
		'{"-f '", 4'd5, 3'd2},
		'{"invoke-obfuscation", 4'd5, 3'd4},
		'{"out-string|-", 4'd5, 3'd3},
		'{"-encodedcommand", 4'd6, 3'd4},
		'{"-enc ", 4'd6, 3'd3},
		'{"frombase64string", 4'd6, 3'd3},
		'{"convert::frombase64", 4'd6, 3'd3},
		'{232'h6261736536345f6465636f646528, 4'd6, 3'd3},
		'{"virtualalloc", 4'd7, 3'd4},
		'{"writeprocessmemory", 4'd7, 3'd4},
		'{"createthread", 4'd7, 3'd3},
		'{"rtlmovememory", 4'd7, 3'd4},
		'{"getprocaddress", 4'd7, 3'd3},
		'{"encrypt-file", 4'd8, 3'd5},
		'{"aes.create()", 4'd8, 3'd4},
		'{"get-childitem -recurse", 4'd8, 3'd3},
		'{"vssadmin delete shadows", 4'd8, 3'd5},
		'{"bcdedit /set", 4'd8, 3'd4},
		'{"wbadmin delete catalog", 4'd8, 3'd5},
		'{"setup.py", 4'd9, 3'd2},
		'{"postinstall", 4'd9, 3'd2},
		'{"preinstall", 4'd9, 3'd2},
		'{"install.js", 4'd9, 3'd3},
		'{"subprocess.popen", 4'd9, 3'd3},
		'{"os.system(", 4'd9, 3'd3},
		'{"eval(compile(", 4'd9, 3'd4},
		'{"__import__(", 4'd9, 3'd4},
		'{"regsvr32 /s /u", 4'd10, 3'd4},
		'{"mshta vbscript:", 4'd10, 3'd4},
		'{"wmic process call create", 4'd10, 3'd4},
		'{"certutil -decode", 4'd10, 3'd4},
		'{"certutil -urlcache", 4'd10, 3'd4},
		'{"msiexec /q", 4'd10, 3'd3},
		'{"expand-archive", 4'd10, 3'd2}
	};

endpackage

// ----- rtl/core/psc_req_if.sv -----
// Input channel of the scanner: one message byte and the event's prior fields per word.
interface psc_req_if;
	logic            valid;
	logic            ready;
	psc_pkg::byte_t  data_byte;
	logic            last_byte;
	psc_pkg::sev_t   prior_severity;
	psc_pkg::cat_t   prior_category;

	modport source (output valid, data_byte, last_byte, prior_severity, prior_category,
		input ready);
	modport sink (input valid, data_byte, last_byte, prior_severity, prior_category,
		output ready);
endinterface

// ----- rtl/core/psc_rsp_if.sv -----
// Result channel of the scanner: the event's resulting severity and category.
interface psc_rsp_if;
	logic          valid;
	logic          ready;
	psc_pkg::sev_t severity;
	psc_pkg::cat_t category;

	modport source (output valid, severity, category, input ready);
	modport sink (input valid, severity, category, output ready);
endinterface

// ----- rtl/core/psc_match.sv -----
// Parallel comparators of every table pattern against the newest bytes of the window.
module psc_match (
	input  psc_pkg::win_t  win,
	output psc_pkg::hits_t hits
);

	// A pattern hits when each of its non-padding bytes equals the window byte at the same age.
	always_comb begin
		hits = '1;
		for (int i = 0; i < psc_pkg::PATTERN_TOTAL; i++) begin
			for (int k = 0; k < psc_pkg::WINDOW_LEN; k++) begin
				if (psc_pkg::PAT_ROM[i].txt[8*k +: 8] != 8'h00 &&
						win[8*k +: 8] != psc_pkg::PAT_ROM[i].txt[8*k +: 8]) begin
					hits[i] = 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/core/psc_select.sv -----
// Picks the best found pattern and merges it with the event's prior severity and category.
module psc_select (
	input  psc_pkg::hits_t found,
	input  psc_pkg::sev_t  prior_severity,
	input  psc_pkg::cat_t  prior_category,
	output psc_pkg::sev_t  severity,
	output psc_pkg::cat_t  category
);

	logic [psc_pkg::CLASS_TOTAL-1:0] pres [psc_pkg::SEV_LEVELS];
	psc_pkg::cat_t                   first_cat [psc_pkg::SEV_LEVELS];
	psc_pkg::sev_t                   top_sev;
	psc_pkg::cat_t                   top_cat;
	psc_pkg::sev_t                   merged_sev;

	// Fold the found bits into one class vector per severity level.
	always_comb begin
		for (int l = 0; l < psc_pkg::SEV_LEVELS; l++) begin
			pres[l] = '0;
		end
		for (int i = 0; i < psc_pkg::PATTERN_TOTAL; i++) begin
			if (found[i]) begin
				pres[psc_pkg::PAT_ROM[i].sev][4'(psc_pkg::PAT_ROM[i].cls - 4'd1)] = 1'b1;
			end
		end
	end

	// Classes follow table order, so the lowest class at a level is the lowest table index.
	always_comb begin
		for (int l = 0; l < psc_pkg::SEV_LEVELS; l++) begin
			first_cat[l] = psc_pkg::CAT_NONE;
			for (int c = psc_pkg::CLASS_TOTAL - 1; c >= 0; c--) begin
				if (pres[l][c]) begin
					first_cat[l] = 4'(c + 1);
				end
			end
		end
	end

	// The highest level with any found pattern wins.
	always_comb begin
		top_sev = psc_pkg::LEVEL_NONE;
		top_cat = psc_pkg::CAT_NONE;
		for (int l = 1; l < psc_pkg::SEV_LEVELS; l++) begin
			if (|pres[l]) begin
				top_sev = 3'(l);
				top_cat = first_cat[l];
			end
		end
	end

	// Raise the prior severity, replace the category on a match, and never report none.
	always_comb begin
		merged_sev = (top_sev > prior_severity) ? top_sev : prior_severity;
		severity   = (merged_sev == psc_pkg::LEVEL_NONE) ? psc_pkg::LEVEL_INFO : merged_sev;
		category   = (top_cat != psc_pkg::CAT_NONE) ? top_cat : prior_category;
	end

endmodule

// ----- rtl/core/severity_pattern_scanner_core.sv -----
// Top level of the severity pattern scanner: window, match stage, found bits and result register.
// The scanner takes one message byte per word and accepts a word in every cycle; the input
// stalls only while a last word in the match stage faces a full result register that is not
// being drained. Letters are folded to lower case and shifted into a 29-byte window in the
// cycle a word is accepted, and the 65 pattern comparators run on the updated window in that
// same cycle. A zero byte, or reaching 65536 bytes, stops matching for the rest of the
// message. The result for a message is registered when its last word leaves the match stage,
// and the next message may start in the cycle right after that last word unless the input
// stalls. All state clears with the last word, so messages are independent.
module severity_pattern_scanner_core (
	input  logic clk,
	input  logic arst_n,
	psc_req_if.sink   req,
	psc_rsp_if.source rsp
);

	// Accept stage state.
	psc_pkg::win_t                win_q;
	logic [psc_pkg::CNT_W-1:0]    bytes_seen_q;
	logic                         stopped_q;

	// Match stage registers.
	logic                         valid_s1;
	psc_pkg::hits_t               hits_s1;
	logic                         last_s1;
	psc_pkg::sev_t                prior_sev_s1;
	psc_pkg::cat_t                prior_cat_s1;

	// Found bits and result register.
	psc_pkg::hits_t               found_q;
	logic                         rsp_valid_q;
	psc_pkg::sev_t                severity_q;
	psc_pkg::cat_t                category_q;

	logic                         accept;
	logic                         limit_hit;
	logic                         take;
	logic                         stop_now;
	psc_pkg::byte_t               folded;
	psc_pkg::win_t                win_shift;
	psc_pkg::hits_t               hits_new;
	logic                         adv_s1;
	psc_pkg::hits_t               found_all;
	psc_pkg::sev_t                sel_sev;
	psc_pkg::cat_t                sel_cat;

	// Handshake: a non-last word always drains; a last word needs room in the result register.
	assign adv_s1    = valid_s1 && (!last_s1 || !rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	// Case folding and the decision whether this byte enters the window.
	assign folded    = (req.data_byte >= 8'h41 && req.data_byte <= 8'h5a) ?
		8'(req.data_byte + 8'd32) : req.data_byte;
	assign limit_hit = bytes_seen_q >= psc_pkg::CNT_W'(psc_pkg::SCAN_LIMIT);
	assign take      = accept && !stopped_q && req.data_byte != 8'h00 && !limit_hit;
	assign stop_now  = accept && !stopped_q && !take;
	assign win_shift = {win_q[psc_pkg::WIN_BITS-9:0], folded};

	psc_match u_match (
		.win  (win_shift),
		.hits (hits_new)
	);

	// Window, byte count and stop flag; the last word clears them for the next message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q        <= '0;
			bytes_seen_q <= '0;
			stopped_q    <= 1'b0;
		end else if (accept) begin
			if (req.last_byte) begin
				win_q        <= '0;
				bytes_seen_q <= '0;
				stopped_q    <= 1'b0;
			end else begin
				if (take) begin
					win_q        <= win_shift;
					bytes_seen_q <= bytes_seen_q + psc_pkg::CNT_W'(1);
				end
				if (stop_now) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	// Match stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Match stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			hits_s1      <= take ? hits_new : '0;
			last_s1      <= req.last_byte;
			prior_sev_s1 <= req.prior_severity;
			prior_cat_s1 <= req.prior_category;
		end
	end

	// Found bits collect hits until the last word of the message leaves the match stage.
	assign found_all = found_q | hits_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (adv_s1) begin
			found_q <= last_s1 ? '0 : found_all;
		end
	end

	psc_select u_select (
		.found          (found_all),
		.prior_severity (prior_sev_s1),
		.prior_category (prior_cat_s1),
		.severity       (sel_sev),
		.category       (sel_cat)
	);

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			severity_q <= sel_sev;
			category_q <= sel_cat;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.severity = severity_q;
	assign rsp.category = category_q;

	// The found bits are empty once a message's result has been formed.
	a_found_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (found_q == '0))
		else $error("found bits not cleared after a message result");

	// A last word leaves an empty window and a zero count behind.
	a_state_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.last_byte) |=> (win_q == '0 && bytes_seen_q == '0 && !stopped_q))
		else $error("scan state not cleared after the last word");

	// The byte count never passes the scan limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= psc_pkg::CNT_W'(psc_pkg::SCAN_LIMIT))
		else $error("byte count beyond the scan limit");

	// A reported result never carries a severity of none.
	a_sev_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.severity != psc_pkg::LEVEL_NONE))
		else $error("result with severity none");

endmodule
